// ===== design/reb_pkg.sv =====
// Shared types, event codes and the quadrature transition decode.
package reb_pkg;

  typedef enum logic [2:0] {
    EV_CW     = 3'd0,
    EV_CCW    = 3'd1,
    EV_SINGLE = 3'd2,
    EV_DOUBLE = 3'd3,
    EV_LONG   = 3'd4
  } event_kind_t;

  typedef enum logic [2:0] {
    REG_DEBOUNCE     = 3'd0,
    REG_FAST_TURN    = 3'd1,
    REG_LONG_PRESS   = 3'd2,
    REG_DOUBLE_CLICK = 3'd3,
    REG_SWITCH       = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } turn_dir_t;

  localparam logic [1:0] AB_RESET     = 2'b11;
  localparam logic [1:0] STEP_SINGLE  = 2'd1;
  localparam logic [1:0] STEP_DOUBLE  = 2'd2;
  localparam logic [1:0] STEP_NONE    = 2'd0;
  localparam logic [7:0] TALLY_MAX    = 8'd255;

  // Gray-code transition decode; index is {old_ab, new_ab}.
  function automatic turn_dir_t turn_dir(input logic [3:0] idx);
    turn_dir_t dir;
    case (idx)
      4'b0001, 4'b0111, 4'b1110, 4'b1000: dir = DIR_CW;
      4'b0010, 4'b0100, 4'b1101, 4'b1011: dir = DIR_CCW;
      default:                            dir = DIR_NONE;
    endcase
    return dir;
  endfunction

endpackage

// ===== design/rotary_encoder_and_button_events_core.sv =====
// Rotary encoder and push button event decoder, one poll sample per item.
//
//  channel | direction | handshake             | content
//  s_axis  | in        | s_tvalid / s_tready   | one poll sample
//  m_axis  | out       | m_tvalid / m_tready   | zero or one event per sample
//  cfg     | in        | cfg_valid / cfg_ready | register index and value
//
// One sample is taken per cycle while s_tready is high; the decode is a single
// combinational pass from the accepted sample and the held state into the
// result register, read out in the following cycle. Samples that yield no event
// leave nothing on the output. rst is synchronous and restores register
// defaults and decoder state. A stalled output blocks new samples only while
// the result register is full and not being taken; cfg_ready is always high.
module rotary_encoder_and_button_events_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [0] pin_a, [1] pin_b, [2] key_down, [34:3] now_ms
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [2:0]  m_tuser,   // [2:0] event_kind
  output logic [7:0]  m_tdata,   // [1:0] step_size
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic [15:0] settle_ms;
  logic [15:0] quick_ms;
  logic [15:0] hold_ms;
  logic [15:0] click_gap_ms;
  logic        switch_present;

  // decoder state
  logic [1:0]  previous_ab;
  logic [31:0] last_move_time;
  logic        button_held;
  logic [31:0] press_start_time;
  logic [31:0] release_time;
  logic [7:0]  click_tally;

  logic [1:0]  previous_ab_next;
  logic [31:0] last_move_time_next;
  logic        button_held_next;
  logic [31:0] press_start_time_next;
  logic [31:0] release_time_next;
  logic [7:0]  click_tally_next;

  logic        pin_a, pin_b, key_down;
  logic [31:0] now_ms;
  logic [1:0]  ab;
  logic        accept;
  reb_pkg::turn_dir_t dir;
  logic [31:0] move_gap, hold_gap, quiet_gap, press_base, release_base;
  logic [7:0]  tally_mid;
  logic        has_result;
  reb_pkg::event_kind_t kind;
  logic [1:0]  step;

  assign pin_a    = s_tdata[0];
  assign pin_b    = s_tdata[1];
  assign key_down = s_tdata[2];
  assign now_ms   = s_tdata[34:3];
  assign ab       = {pin_a, pin_b};

  assign s_tready  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  assign dir      = reb_pkg::turn_dir({previous_ab, ab});
  assign move_gap = now_ms - last_move_time;

  always_comb begin
    previous_ab_next      = ab;
    last_move_time_next   = last_move_time;
    button_held_next      = button_held;
    press_start_time_next = press_start_time;
    release_time_next     = release_time;
    click_tally_next      = click_tally;
    has_result            = 1'b0;
    kind                  = reb_pkg::EV_CW;
    step                  = reb_pkg::STEP_NONE;
    press_base            = (key_down && !button_held) ? now_ms : press_start_time;
    hold_gap              = now_ms - press_base;
    release_base          = (!key_down && button_held) ? now_ms : release_time;
    quiet_gap             = now_ms - release_base;
    tally_mid             = click_tally;
    if (!key_down && button_held && click_tally != reb_pkg::TALLY_MAX) begin
      tally_mid = click_tally + 8'd1;
    end

    if (ab != previous_ab && dir != reb_pkg::DIR_NONE &&
        move_gap >= {16'd0, settle_ms}) begin
      has_result          = 1'b1;
      kind                = (dir == reb_pkg::DIR_CW) ? reb_pkg::EV_CW : reb_pkg::EV_CCW;
      step                = (move_gap < {16'd0, quick_ms}) ?
                            reb_pkg::STEP_DOUBLE : reb_pkg::STEP_SINGLE;
      last_move_time_next = now_ms;
    end else if (switch_present) begin
      press_start_time_next = press_base;
      if (key_down) begin
        button_held_next = 1'b1;
        if (hold_gap >= {16'd0, hold_ms}) begin
          // long press re-arms on the next held sample
          button_held_next = 1'b0;
          click_tally_next = 8'd0;
          has_result       = 1'b1;
          kind             = reb_pkg::EV_LONG;
        end
      end
      if (!(key_down && hold_gap >= {16'd0, hold_ms})) begin
        if (!key_down) begin
          button_held_next = 1'b0;
        end
        release_time_next = release_base;
        click_tally_next  = tally_mid;
        if (tally_mid != 8'd0 && quiet_gap > {16'd0, click_gap_ms}) begin
          has_result       = 1'b1;
          kind             = (tally_mid == 8'd1) ? reb_pkg::EV_SINGLE : reb_pkg::EV_DOUBLE;
          click_tally_next = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ms        <= 16'd2;
      quick_ms         <= 16'd60;
      hold_ms          <= 16'd800;
      click_gap_ms     <= 16'd300;
      switch_present   <= 1'b1;
      previous_ab      <= reb_pkg::AB_RESET;
      last_move_time   <= 32'd0;
      button_held      <= 1'b0;
      press_start_time <= 32'd0;
      release_time     <= 32'd0;
      click_tally      <= 8'd0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          reb_pkg::REG_DEBOUNCE:     settle_ms      <= cfg_data;
          reb_pkg::REG_FAST_TURN:    quick_ms       <= cfg_data;
          reb_pkg::REG_LONG_PRESS:   hold_ms        <= cfg_data;
          reb_pkg::REG_DOUBLE_CLICK: click_gap_ms   <= cfg_data;
          reb_pkg::REG_SWITCH:       switch_present <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        previous_ab      <= previous_ab_next;
        last_move_time   <= last_move_time_next;
        button_held      <= button_held_next;
        press_start_time <= press_start_time_next;
        release_time     <= release_time_next;
        click_tally      <= click_tally_next;
        m_tvalid         <= has_result;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      m_tuser <= kind;
      m_tdata <= {6'd0, step};
    end
  end

  a_step_matches_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == reb_pkg::EV_CW || m_tuser == reb_pkg::EV_CCW)
                  == (m_tdata[1:0] != reb_pkg::STEP_NONE)))
    else $error("step size does not match event kind");

  a_long_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && has_result && kind == reb_pkg::EV_LONG) |=>
      (click_tally == 8'd0 && !button_held))
    else $error("long press left button state armed");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (accept && has_result) |=> m_tvalid)
    else $error("event lost");

  a_switch_absent: assert property (@(posedge clk) disable iff (rst)
    (accept && !switch_present) |=>
      ($stable(button_held) && $stable(click_tally) && $stable(release_time)))
    else $error("button state changed with switch absent");

endmodule

// ===== test/tb_top.sv =====
// Testbench for the rotary encoder and button event decoder: directed and random poll samples.

class event_scoreboard;
  logic [15:0] settle_ms;
  logic [15:0] quick_ms;
  logic [15:0] hold_ms;
  logic [15:0] click_gap_ms;
  logic        switch_on;

  logic [1:0]  prev_ab;
  logic [31:0] last_move;
  logic [31:0] press_start;
  logic [31:0] release_at;
  logic        held;
  logic [7:0]  tally;

  logic [4:0]  events_due[$];   // {step_size, event_kind}
  int          mismatches;

  function new();
    settle_ms       = 16'd2;
    quick_ms        = 16'd60;
    hold_ms         = 16'd800;
    click_gap_ms    = 16'd300;
    switch_on       = 1'b1;
    prev_ab         = reb_pkg::AB_RESET;
    last_move       = '0;
    press_start     = '0;
    release_at      = '0;
    held            = 1'b0;
    tally           = '0;
    mismatches      = 0;
  endfunction

  function void set_reg(reb_pkg::reg_index_t idx, logic [15:0] val);
    case (idx)
      reb_pkg::REG_DEBOUNCE:     settle_ms = val;
      reb_pkg::REG_FAST_TURN:    quick_ms = val;
      reb_pkg::REG_LONG_PRESS:   hold_ms = val;
      reb_pkg::REG_DOUBLE_CLICK: click_gap_ms = val;
      reb_pkg::REG_SWITCH:       switch_on = val[0];
      default: ;
    endcase
  endfunction

  // Position along the quadrature cycle 00 -> 01 -> 11 -> 10; clockwise adds one.
  function logic [1:0] wheel_pos(logic [1:0] ab);
    return {ab[1], ab[1] ^ ab[0]};
  endfunction

  function void note_sample(logic a, logic b, logic key, logic [31:0] now);
    logic [1:0]  ab;
    logic [1:0]  p_old;
    logic [1:0]  p_new;
    logic [31:0] gap;
    logic [31:0] held_for;
    logic [31:0] quiet;
    logic [2:0]  kind;
    ab = {a, b};
    if (ab != prev_ab) begin
      p_old = wheel_pos(prev_ab);
      p_new = wheel_pos(ab);
      prev_ab = ab;
      if (p_new == p_old + 2'd1 || p_old == p_new + 2'd1) begin
        gap = now - last_move;
        if (gap >= 32'(settle_ms)) begin
          last_move = now;
          kind = (p_new == p_old + 2'd1) ? reb_pkg::EV_CW : reb_pkg::EV_CCW;
          events_due.push_back({(gap < 32'(quick_ms)) ? reb_pkg::STEP_DOUBLE
                                                     : reb_pkg::STEP_SINGLE, kind});
          return;
        end
      end
    end
    if (!switch_on) return;
    if (key && !held) begin
      held = 1'b1;
      press_start = now;
    end
    held_for = now - press_start;
    if (key && held && held_for >= 32'(hold_ms)) begin
      held = 1'b0;
      tally = '0;
      events_due.push_back({reb_pkg::STEP_NONE, reb_pkg::EV_LONG});
      return;
    end
    if (!key && held) begin
      held = 1'b0;
      release_at = now;
      if (tally != reb_pkg::TALLY_MAX) tally = tally + 8'd1;
    end
    quiet = now - release_at;
    if (tally != 8'd0 && quiet > 32'(click_gap_ms)) begin
      kind = (tally == 8'd1) ? reb_pkg::EV_SINGLE : reb_pkg::EV_DOUBLE;
      tally = '0;
      events_due.push_back({reb_pkg::STEP_NONE, kind});
    end
  endfunction

  function void check_event(logic [2:0] user, logic [7:0] data);
    logic [4:0] want;
    if (events_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected event: kind %0d step %0d", user, data[1:0]);
      return;
    end
    want = events_due.pop_front();
    if (user !== want[2:0] || data[1:0] !== want[4:3]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("event mismatch: expected kind %0d step %0d, got kind %0d step %0d",
                 want[2:0], want[4:3], user, data[1:0]);
    end
  endfunction

  function int pending();
    return events_due.size();
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [0] pin_a, [1] pin_b, [2] key_down, [34:3] now_ms
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [2:0]  m_tuser;        // [2:0] event_kind
  logic [7:0]  m_tdata;        // [1:0] step_size
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reb_pkg::reg_index_t cfg_index = reb_pkg::REG_DEBOUNCE;
  logic [15:0] cfg_data = '0;

  event_scoreboard sb;

  // stimulus state: last levels sent and the running millisecond clock
  logic [1:0]  wheel_ab = reb_pkg::AB_RESET;
  logic        key_level = 1'b0;
  logic [31:0] clock_ms = '0;
  bit          spin_cw = 1'b1;
  bit          src_idle_on = 1'b0;
  bit          sink_stall_on = 1'b0;
  bit          src_high = 1'b0;

  rotary_encoder_and_button_events_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (sink_stall_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_event(m_tuser, m_tdata);
  end

  task automatic send_sample(logic a, logic b, logic key, logic [31:0] now);
    int gap;
    gap = src_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      if (src_high) s_tvalid <= 1'b0;
      src_high = 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    src_high = 1'b1;
    s_tdata  <= {5'd0, now, key, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(a, b, key, now);
  endtask

  // Hold the source until every pending event has come out.
  task automatic drain_events();
    if (src_high) s_tvalid <= 1'b0;
    src_high = 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic load_config(logic [15:0] deb, logic [15:0] fast, logic [15:0] lng,
                             logic [15:0] dbl, logic sw);
    logic [15:0] vals[5];
    reb_pkg::reg_index_t regs[5];
    vals = '{deb, fast, lng, dbl, {15'd0, sw}};
    regs = '{reb_pkg::REG_DEBOUNCE, reb_pkg::REG_FAST_TURN, reb_pkg::REG_LONG_PRESS,
             reb_pkg::REG_DOUBLE_CLICK, reb_pkg::REG_SWITCH};
    drain_events();
    // a sample without an event may still be in the pipeline
    repeat (4) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int count, int max_step);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 9);
      // advance one detent, jump both lines, or stay put
      if (r < 6)
        wheel_ab = spin_cw ? {wheel_ab[0], ~wheel_ab[1]} : {~wheel_ab[0], wheel_ab[1]};
      else if (r == 6)
        wheel_ab = ~wheel_ab;
      if ($urandom_range(0, 7) == 0) spin_cw = ~spin_cw;
      if ($urandom_range(0, 5) == 0) key_level = ~key_level;
      r = $urandom_range(0, 63);
      if (r == 0)
        clock_ms = $urandom;
      else if (r < 6)
        clock_ms += $urandom_range(0, 4 * max_step);
      else
        clock_ms += $urandom_range(0, max_step);
      send_sample(wheel_ab[1], wheel_ab[0], key_level, clock_ms);
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part on reset defaults
    send_sample(1'b1, 1'b1, 1'b0, 32'd0);
    send_sample(1'b1, 1'b0, 1'b0, 32'd5);
    send_sample(1'b0, 1'b0, 1'b0, 32'd6);       // too soon after the last move
    send_sample(1'b0, 1'b1, 1'b0, 32'd100);
    send_sample(1'b0, 1'b0, 1'b0, 32'd200);
    send_sample(1'b1, 1'b1, 1'b0, 32'd300);     // both lines change
    send_sample(1'b1, 1'b1, 1'b1, 32'd400);
    send_sample(1'b1, 1'b1, 1'b0, 32'd450);
    send_sample(1'b1, 1'b1, 1'b0, 32'd751);
    send_sample(1'b1, 1'b1, 1'b1, 32'd800);
    send_sample(1'b1, 1'b1, 1'b0, 32'd810);
    send_sample(1'b1, 1'b1, 1'b1, 32'd820);
    send_sample(1'b1, 1'b1, 1'b0, 32'd830);
    send_sample(1'b1, 1'b1, 1'b0, 32'd1131);
    send_sample(1'b1, 1'b1, 1'b1, 32'd2000);
    send_sample(1'b1, 1'b1, 1'b1, 32'd2800);
    send_sample(1'b1, 1'b1, 1'b1, 32'd2801);
    send_sample(1'b1, 1'b1, 1'b0, 32'd2900);
    send_sample(1'b0, 1'b1, 1'b1, 32'd2950);    // move while pressed skips the button
    send_sample(1'b0, 1'b1, 1'b1, 32'd3300);
    send_sample(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 1'b0, 1'b0, 32'h0000_0001);
    send_sample(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    wheel_ab  = 2'b11;
    key_level = 1'b1;
    clock_ms  = 32'hFFFF_FFFF;

    src_idle_on = 1'b1;
    load_config(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    run_phase(100, 3);

    sink_stall_on = 1'b1;
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    run_phase(100, 30000);

    src_idle_on = 1'b0;
    load_config(16'($urandom_range(0, 20)), 16'($urandom_range(0, 200)),
                16'($urandom_range(0, 500)), 16'($urandom_range(0, 300)), 1'b0);
    run_phase(100, 200);

    src_idle_on = 1'b1;
    load_config(16'($urandom_range(0, 20)), 16'($urandom_range(0, 200)),
                16'($urandom_range(50, 500)), 16'($urandom_range(10, 300)), 1'b1);
    run_phase(60, 40);
    drain_events();
    run_phase(60, 40);

    sink_stall_on = 1'b0;
    load_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b1);
    run_phase(100, 20000);

    // fast presses with no quiet time let the click count run into saturation
    sink_stall_on = 1'b1;
    load_config(16'd2, 16'd60, 16'hFFFF, 16'hFFFF, 1'b1);
    key_level = 1'b0;
    for (int n = 0; n < 560; n++) begin
      key_level = ~key_level;
      clock_ms += 32'd1;
      send_sample(wheel_ab[1], wheel_ab[0], key_level, clock_ms);
    end
    clock_ms += 32'd70000;
    send_sample(wheel_ab[1], wheel_ab[0], 1'b0, clock_ms);

    drain_events();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
